>>> design/lnw_pkg.sv
// ----------------------------------------------------------------------------
// lnw_pkg
// Types, codes and the power-up table shared by the character LCD writer.
// ----------------------------------------------------------------------------
package lnw_pkg;

    localparam int COLUMNS_DEFAULT       = 16;
    localparam int PULSE_HALF_MS_DEFAULT = 2;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 8;
    localparam int WAIT_W   = 9;
    localparam int NIBBLE_W = 4;
    localparam int ADDR_W   = 7;
    localparam int STEP_W   = 4;
    localparam int EXTRA_W  = 5;

    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSTR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEXT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

    localparam logic REG_ROW_ONE_START = 1'b0;
    localparam logic REG_ROW_TWO_START = 1'b1;

    localparam logic [ADDR_W-1:0] ROW_ONE_RESET = 7'd0;
    localparam logic [ADDR_W-1:0] ROW_TWO_RESET = 7'd64;

    localparam logic [VALUE_W-1:0] SET_ADDR_CMD = 8'h80;
    localparam logic [WAIT_W-1:0]  WAIT_MAX     = 9'd511;
    localparam logic [STEP_W-1:0]  INIT_LAST    = 4'd14;

    typedef struct packed {
        logic              wrap;
        logic [ADDR_W-1:0] start;
    } wrap_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic [WAIT_W-1:0]  extra;
        logic               wrap;
        logic [ADDR_W-1:0]  start;
    } item_t;

    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                rs;
        logic                pulse;
        logic [WAIT_W-1:0]   wait_ms;
        logic                last;
    } action_t;

    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                pulse;
        logic [EXTRA_W-1:0]  extra;
    } init_step_t;

    // Power-up run: pure wait, three 0x3 nibbles, 0x2, then 0x28 0x80 0x01 0x06 0x0F.
    function automatic init_step_t init_entry(input logic [STEP_W-1:0] step);
        init_step_t e;
        case (step)
            4'd0:    e = '{nibble: 4'h0, pulse: 1'b0, extra: 5'd20};
            4'd1:    e = '{nibble: 4'h3, pulse: 1'b1, extra: 5'd5};
            4'd2:    e = '{nibble: 4'h3, pulse: 1'b1, extra: 5'd1};
            4'd3:    e = '{nibble: 4'h3, pulse: 1'b1, extra: 5'd1};
            4'd4:    e = '{nibble: 4'h2, pulse: 1'b1, extra: 5'd0};
            4'd5:    e = '{nibble: 4'h2, pulse: 1'b1, extra: 5'd0};
            4'd6:    e = '{nibble: 4'h8, pulse: 1'b1, extra: 5'd0};
            4'd7:    e = '{nibble: 4'h8, pulse: 1'b1, extra: 5'd0};
            4'd8:    e = '{nibble: 4'h0, pulse: 1'b1, extra: 5'd0};
            4'd9:    e = '{nibble: 4'h0, pulse: 1'b1, extra: 5'd0};
            4'd10:   e = '{nibble: 4'h1, pulse: 1'b1, extra: 5'd0};
            4'd11:   e = '{nibble: 4'h0, pulse: 1'b1, extra: 5'd0};
            4'd12:   e = '{nibble: 4'h6, pulse: 1'b1, extra: 5'd0};
            4'd13:   e = '{nibble: 4'h0, pulse: 1'b1, extra: 5'd0};
            4'd14:   e = '{nibble: 4'hF, pulse: 1'b1, extra: 5'd0};
            default: e = '{nibble: 4'h0, pulse: 1'b0, extra: 5'd0};
        endcase
        return e;
    endfunction

    function automatic logic [WAIT_W-1:0] sat_wait(input logic [WAIT_W:0] sum);
        return (sum > {1'b0, WAIT_MAX}) ? WAIT_MAX : sum[WAIT_W-1:0];
    endfunction

endpackage

>>> design/lnw_cursor.sv
// ----------------------------------------------------------------------------
// lnw_cursor
// Column and row tracking for text, and the two row start registers.
// ----------------------------------------------------------------------------
module lnw_cursor #(
    parameter int COLUMNS = lnw_pkg::COLUMNS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_addr,
    input  logic [lnw_pkg::ADDR_W-1:0]  cfg_wr_data,
    input  logic                        text_take,
    input  logic                        first_of_text,
    output lnw_pkg::wrap_t              wrap_info
);
    import lnw_pkg::*;

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    logic [ADDR_W-1:0] row_one_reg, row_two_reg;
    logic [COL_W-1:0]  column_reg, column_next, col_eff;
    logic              row_reg, row_next, row_eff;

    always_comb begin
        col_eff = first_of_text ? '0 : column_reg;
        row_eff = first_of_text ? 1'b0 : row_reg;
        if (col_eff >= COL_W'(COLUMNS - 1)) begin
            column_next = '0;
            row_next    = ~row_eff;
        end else begin
            column_next = col_eff + 1'b1;
            row_next    = row_eff;
        end
        wrap_info.wrap  = (col_eff >= COL_W'(COLUMNS - 1));
        wrap_info.start = row_next ? row_two_reg : row_one_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_one_reg <= ROW_ONE_RESET;
            row_two_reg <= ROW_TWO_RESET;
            column_reg  <= '0;
            row_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_addr == REG_ROW_ONE_START) begin
                row_one_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_addr == REG_ROW_TWO_START) begin
                row_two_reg <= cfg_wr_data;
            end
            if (text_take) begin
                column_reg <= column_next;
                row_reg    <= row_next;
            end
        end
    end

endmodule

>>> design/lnw_expand.sv
// ----------------------------------------------------------------------------
// lnw_expand
// Produces the bus action for one step of the item held in the item register.
// ----------------------------------------------------------------------------
module lnw_expand #(
    parameter int PULSE_HALF_MS = lnw_pkg::PULSE_HALF_MS_DEFAULT
) (
    input  lnw_pkg::item_t              item,
    input  logic [lnw_pkg::STEP_W-1:0]  step,
    output lnw_pkg::action_t            act
);
    import lnw_pkg::*;

    localparam logic [WAIT_W:0] HALF = (WAIT_W + 1)'(PULSE_HALF_MS);

    init_step_t         ie;
    logic [VALUE_W-1:0] byte_sel;
    logic [WAIT_W-1:0]  half_wait;

    always_comb begin
        ie        = init_entry(step);
        half_wait = sat_wait(HALF);
        byte_sel  = step[1] ? (SET_ADDR_CMD | {1'b0, item.start}) : item.value;
        act       = '0;
        if (item.kind == KIND_INIT) begin
            act.nibble  = ie.nibble;
            act.pulse   = ie.pulse;
            act.wait_ms = ie.pulse ? sat_wait(HALF + (WAIT_W + 1)'(ie.extra))
                                   : WAIT_W'(ie.extra);
            act.last    = (step == INIT_LAST);
        end else begin
            act.nibble  = step[0] ? byte_sel[3:0] : byte_sel[7:4];
            act.rs      = (item.kind == KIND_TEXT) && !step[1];
            act.pulse   = 1'b1;
            act.wait_ms = (step[0] && item.kind == KIND_INSTR)
                          ? sat_wait(HALF + {1'b0, item.extra}) : half_wait;
            if (item.kind == KIND_TEXT && item.wrap) begin
                act.last = (step == STEP_W'(3));
            end else begin
                act.last = (step == STEP_W'(1));
            end
        end
    end

endmodule

>>> design/lcd_4bit_nibble_writer_with_wrap_top.sv
// ----------------------------------------------------------------------------
// lcd_4bit_nibble_writer_with_wrap_top
// Expands init requests, instruction bytes and text characters into a run of
// 4-bit LCD bus actions, wrapping text to the other row at the end of a row.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  tdata: value, wait_after_ms; tuser: kind, first
// m_        out  m_tvalid/m_tready  tdata: nibble, wait_ms; tuser: rs, pulse; tlast
// cfg_      in   cfg_wr_en          cfg_addr selects the row start, cfg_wr_data
//
// One action leaves per cycle from the step counter over the item register, and
// an item has as many actions as its kind gives: 15 for init, 2 for an
// instruction, 2 or 4 for a character. The next item is taken in the cycle its
// predecessor's last action is loaded. A stalled output holds the sequencer.
// Reset is synchronous and returns the row starts to 0 and 64.
// ----------------------------------------------------------------------------
module lcd_4bit_nibble_writer_with_wrap_top #(
    parameter int COLUMNS       = lnw_pkg::COLUMNS_DEFAULT,
    parameter int PULSE_HALF_MS = lnw_pkg::PULSE_HALF_MS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] value, [16:8] wait_after_ms, zero fill
    input  logic [2:0]  s_tuser,   // [1:0] kind, [2] first_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] nibble, [12:4] wait_ms, zero fill
    output logic [1:0]  m_tuser,   // [0] register_select, [1] pulse
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [6:0]  cfg_wr_data
);
    import lnw_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    item_t             item_reg;
    action_t           out_reg;
    logic              m_valid_reg;
    action_t           act;
    wrap_t             wrap_info;
    logic              out_free, emit, done, accept, take;
    logic [KIND_W-1:0] s_kind;

    assign s_kind   = s_tuser[1:0];
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = busy_reg && out_free;
    assign done     = emit && act.last;
    assign s_tready = !busy_reg || done;
    assign accept   = s_tvalid && s_tready;
    assign take     = accept && (s_kind != KIND_NONE);

    lnw_cursor #(.COLUMNS(COLUMNS)) u_cursor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .text_take     (take && s_kind == KIND_TEXT),
        .first_of_text (s_tuser[2]),
        .wrap_info     (wrap_info)
    );

    lnw_expand #(.PULSE_HALF_MS(PULSE_HALF_MS)) u_expand (
        .item (item_reg),
        .step (step_reg),
        .act  (act)
    );

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (take) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (emit) begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.kind  <= s_kind;
            item_reg.value <= s_tdata[7:0];
            item_reg.extra <= s_tdata[16:8];
            item_reg.wrap  <= wrap_info.wrap;
            item_reg.start <= wrap_info.start;
        end
        if (emit) begin
            out_reg <= act;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_reg.wait_ms, out_reg.nibble};
    assign m_tuser  = {out_reg.pulse, out_reg.rs};
    assign m_tlast  = out_reg.last;

endmodule

>>> design/lnw_checker.sv
// ----------------------------------------------------------------------------
// lnw_checker
// Port-level checks on the LCD writer's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module lnw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A pure wait drives no nibble and selects the instruction register.
    a_wait_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[3:0] == 4'h0 && !m_tuser[0])
        else $error("pure wait carries data");

    // The only pure wait opens the init run, so it never ends an item.
    a_wait_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> !m_tlast)
        else $error("pure wait marked last");

    a_pulse_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[12:4] != 9'd0)
        else $error("strobe without its low half wait");

endmodule

bind lcd_4bit_nibble_writer_with_wrap_top lnw_checker u_lnw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> sim/lcd_4bit_nibble_writer_with_wrap_top_tb.sv
// ----------------------------------------------------------------------------
// lcd_4bit_nibble_writer_with_wrap_top_tb
// Self-checking bench for the 4-bit character LCD writer. A table of directed
// items comes first. Random strings of text follow, mixed with instructions,
// power-up requests and unused kinds, under several row start settings. A
// behavioural model predicts the actions of items not given typed ones; each
// is checked field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module lcd_4bit_nibble_writer_with_wrap_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lnw_pkg::*;

    localparam int COLS         = COLUMNS_DEFAULT;
    localparam int PULSE_HALF   = PULSE_HALF_MS_DEFAULT;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_DIRECTED   = 25;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               first;
        logic [WAIT_W-1:0]  extra;
        logic               has_typed;
        action_t            hi;
        action_t            lo;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic        cfg_addr;
    logic [6:0]  cfg_wr_data;

    action_t          expected_actions[$];
    action_t          staged_actions[$];
    int               text_column;
    logic             text_row;
    logic [ADDR_W-1:0] row_one_addr;
    logic [ADDR_W-1:0] row_two_addr;

    logic    cur_has_typed;
    action_t cur_hi;
    action_t cur_lo;

    int fail_count  = 0;
    int idle_cycles = 0;
    int burst_left;
    int hold_asks   = 0;
    int holds_done  = 0;

    stim_row_t stim_rows [N_DIRECTED];

    lcd_4bit_nibble_writer_with_wrap_top DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic void stage_action(input logic [3:0] nib, input logic rs,
                                         input logic pulse, input int unsigned wait_len);
        action_t a;
        a.nibble  = nib;
        a.rs      = rs;
        a.pulse   = pulse;
        a.wait_ms = (wait_len > WAIT_MAX) ? WAIT_MAX : wait_len[WAIT_W-1:0];
        a.last    = 1'b0;
        staged_actions.push_back(a);
    endfunction

    function automatic void stage_byte(input logic [7:0] b, input logic rs,
                                       input int unsigned extra);
        stage_action(b[7:4], rs, 1'b1, PULSE_HALF);
        stage_action(b[3:0], rs, 1'b1, PULSE_HALF + extra);
    endfunction

    function automatic void expand_item(input logic [KIND_W-1:0] kind,
                                        input logic [VALUE_W-1:0] value,
                                        input logic first, input logic [WAIT_W-1:0] extra);
        logic [7:0] setup_bytes [5] = '{8'h28, 8'h80, 8'h01, 8'h06, 8'h0F};
        logic [ADDR_W-1:0] start;
        staged_actions.delete();
        case (kind)
            KIND_INIT: begin
                stage_action(4'h0, 1'b0, 1'b0, 20);
                stage_action(4'h3, 1'b0, 1'b1, PULSE_HALF + 5);
                stage_action(4'h3, 1'b0, 1'b1, PULSE_HALF + 1);
                stage_action(4'h3, 1'b0, 1'b1, PULSE_HALF + 1);
                stage_action(4'h2, 1'b0, 1'b1, PULSE_HALF);
                foreach (setup_bytes[i]) stage_byte(setup_bytes[i], 1'b0, 0);
            end
            KIND_INSTR: begin
                stage_byte(value, 1'b0, {23'b0, extra});
            end
            KIND_TEXT: begin
                if (first) begin
                    text_column = 0;
                    text_row    = 1'b0;
                end
                stage_byte(value, 1'b1, 0);
                if (text_column >= COLS - 1) begin
                    text_column = 0;
                    text_row    = ~text_row;
                    start       = text_row ? row_two_addr : row_one_addr;
                    stage_byte(SET_ADDR_CMD | {1'b0, start}, 1'b0, 0);
                end else begin
                    text_column++;
                end
            end
            default: begin
            end
        endcase
        if (staged_actions.size() != 0) staged_actions[$].last = 1'b1;
    endfunction

    always @(posedge aclk) begin : bus_watch
        action_t want;
        if (!aresetn) begin
            text_column  = 0;
            text_row     = 1'b0;
            row_one_addr = ROW_ONE_RESET;
            row_two_addr = ROW_TWO_RESET;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_ROW_ONE_START) row_one_addr = cfg_wr_data;
                else row_two_addr = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                expand_item(s_tuser[1:0], s_tdata[7:0], s_tuser[2], s_tdata[16:8]);
                if (cur_has_typed) begin
                    expected_actions.push_back(cur_hi);
                    expected_actions.push_back(cur_lo);
                end else begin
                    foreach (staged_actions[i]) expected_actions.push_back(staged_actions[i]);
                end
            end
            if (m_tvalid && m_tready) begin
                if (expected_actions.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected nibble %h rs %b pulse %b wait %0d last %b",
                                 $realtime, m_tdata[3:0], m_tuser[0], m_tuser[1],
                                 m_tdata[12:4], m_tlast);
                    fail_count++;
                end else begin
                    want = expected_actions.pop_front();
                    if (m_tdata[3:0] !== want.nibble || m_tuser[0] !== want.rs ||
                        m_tuser[1] !== want.pulse || m_tdata[12:4] !== want.wait_ms ||
                        m_tlast !== want.last) begin
                        if (fail_count < 10) begin
                            $write("%0t: expected nibble %h rs %b pulse %b wait %0d last %b,",
                                   $realtime, want.nibble, want.rs, want.pulse,
                                   want.wait_ms, want.last);
                            $display(" got nibble %h rs %b pulse %b wait %0d last %b",
                                     m_tdata[3:0], m_tuser[0], m_tuser[1],
                                     m_tdata[12:4], m_tlast);
                        end
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $realtime, STALL_LIMIT);
            $display("FAIL lcd_4bit_nibble_writer_with_wrap_top");
            $finish;
        end
    end

    initial begin : receiver
        int mode;
        int span;
        int tick;
        m_tready = 1'b0;
        tick     = 0;
        forever begin
            if (hold_asks != holds_done) begin
                holds_done++;
                repeat (HOLD_CYCLES) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 80);
                repeat (span) begin
                    @(negedge aclk);
                    tick++;
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 4) != 0);
                        default: m_tready <= (tick % 3 == 0);
                    endcase
                end
            end
        end
    end

    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                             input logic first, input logic [WAIT_W-1:0] extra,
                             input logic has_typed, input action_t hi, input action_t lo);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        burst_left--;
        s_tvalid      <= 1'b1;
        s_tdata       <= {7'b0, extra, value};
        s_tuser       <= {first, kind};
        cur_has_typed = has_typed;
        cur_hi        = hi;
        cur_lo        = lo;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_row_start(input logic addr, input logic [ADDR_W-1:0] start);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= start;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(input int count, input bit squeeze);
        int sent;
        int chars_left;
        int pick;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               first;
        logic [WAIT_W-1:0]  extra;
        sent       = 0;
        chars_left = 0;
        while (sent < count) begin
            value = 8'($urandom_range(0, 255));
            extra = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(301, 511))
                                                : 9'($urandom_range(0, 300));
            first = 1'b0;
            pick  = $urandom_range(0, 99);
            if (chars_left > 0) begin
                chars_left--;
                kind  = (pick < 8) ? KIND_INSTR : KIND_TEXT;
                first = (pick >= 95);
            end else if (pick < 65) begin
                kind       = KIND_TEXT;
                first      = 1'b1;
                chars_left = $urandom_range(0, 40);
            end else if (pick < 80) begin
                kind  = KIND_INSTR;
                first = 1'($urandom_range(0, 1));
            end else if (pick < 86) begin
                kind = KIND_INIT;
            end else if (pick < 93) begin
                kind  = KIND_NONE;
                first = 1'($urandom_range(0, 1));
            end else begin
                kind = KIND_TEXT;
            end
            send_item(kind, value, first, extra, 1'b0, '0, '0);
            if (kind != KIND_NONE) sent++;
            if (squeeze && sent == 40) begin
                hold_asks++;
                squeeze = 1'b0;
            end
        end
    endtask

    initial begin : stimulus
        stim_rows = '{
            '{KIND_NONE,  8'hFF, 1'b1, 9'd511, 1'b0, '0, '0},
            '{KIND_INSTR, 8'h00, 1'b0, 9'd0,   1'b1,
              '{4'h0, 1'b0, 1'b1, 9'd2, 1'b0}, '{4'h0, 1'b0, 1'b1, 9'd2, 1'b1}},
            '{KIND_INSTR, 8'hFF, 1'b1, 9'd511, 1'b1,
              '{4'hF, 1'b0, 1'b1, 9'd2, 1'b0}, '{4'hF, 1'b0, 1'b1, 9'd511, 1'b1}},
            '{KIND_INSTR, 8'hA5, 1'b0, 9'd300, 1'b1,
              '{4'hA, 1'b0, 1'b1, 9'd2, 1'b0}, '{4'h5, 1'b0, 1'b1, 9'd302, 1'b1}},
            '{KIND_INSTR, 8'h5A, 1'b0, 9'd510, 1'b1,
              '{4'h5, 1'b0, 1'b1, 9'd2, 1'b0}, '{4'hA, 1'b0, 1'b1, 9'd511, 1'b1}},
            '{KIND_INSTR, 8'h3C, 1'b0, 9'd509, 1'b1,
              '{4'h3, 1'b0, 1'b1, 9'd2, 1'b0}, '{4'hC, 1'b0, 1'b1, 9'd511, 1'b1}},
            '{KIND_INIT,  8'hFF, 1'b1, 9'd511, 1'b0, '0, '0},
            '{KIND_TEXT,  8'h00, 1'b1, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h41, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h42, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h43, 1'b0, 9'd511, 1'b0, '0, '0},
            '{KIND_TEXT,  8'h44, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h45, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h46, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h47, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_NONE,  8'h00, 1'b1, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h48, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h49, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h4A, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h4B, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h4C, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h4D, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h4E, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'hFF, 1'b0, 9'd0,   1'b0, '0, '0},
            '{KIND_TEXT,  8'h7E, 1'b1, 9'd0,   1'b0, '0, '0}
        };

        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = 1'b0;
        cfg_wr_data   = '0;
        cur_has_typed = 1'b0;
        cur_hi        = '0;
        cur_lo        = '0;
        burst_left    = 0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i])
            send_item(stim_rows[i].kind, stim_rows[i].value, stim_rows[i].first,
                      stim_rows[i].extra, stim_rows[i].has_typed, stim_rows[i].hi,
                      stim_rows[i].lo);

        write_row_start(REG_ROW_ONE_START, 7'd127);
        write_row_start(REG_ROW_TWO_START, 7'd0);
        random_phase(114, 1'b1);

        write_row_start(REG_ROW_ONE_START, 7'd0);
        write_row_start(REG_ROW_TWO_START, 7'd127);
        random_phase(114, 1'b0);

        write_row_start(REG_ROW_ONE_START, 7'($urandom_range(1, 126)));
        write_row_start(REG_ROW_TWO_START, 7'($urandom_range(1, 126)));
        random_phase(114, 1'b0);

        write_row_start(REG_ROW_ONE_START, 7'd127);
        write_row_start(REG_ROW_TWO_START, 7'd127);
        random_phase(114, 1'b0);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_actions.size() != 0) @(posedge aclk);
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && expected_actions.size() == 0) begin
            $display("PASS lcd_4bit_nibble_writer_with_wrap_top");
        end else begin
            $display("FAIL lcd_4bit_nibble_writer_with_wrap_top");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/lnw_pkg.sv
design/lnw_cursor.sv
design/lnw_expand.sv
design/lcd_4bit_nibble_writer_with_wrap_top.sv
design/lnw_checker.sv
sim/lcd_4bit_nibble_writer_with_wrap_top_tb.sv
